// File: hdl/rde_pkg.sv
package rde_pkg;

  localparam int unsigned DIGIT_STACK_DEPTH = 32;
  localparam int unsigned VALUE_BITS        = 31;

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  // Register index, taken from paddr[2].
  localparam logic REG_RADIX = 1'b0;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h37;  // 'A' minus ten
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] radix;
  } rde_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rde_div_rsp_t;

  // Out-of-range register values are clamped to the nearest legal base.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] char_of(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_TEN) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_LETTER + CHAR_W'(d);
    end
    return res;
  endfunction

endpackage

// File: hdl/rde_if.sv
interface rde_in_if import rde_pkg::*; #(
  parameter int unsigned VALUE_BITS = rde_pkg::VALUE_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rde_out_if import rde_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic [CHAR_W-1:0]  digit_char;
  logic               last_digit;

  modport source (output valid, output digit, output digit_char, output last_digit,
                  input ready);
  modport sink   (input valid, input digit, input digit_char, input last_digit,
                  output ready);
endinterface

// File: hdl/rde_ram.sv
module rde_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rde_divider.sv
// Restoring division of an unsigned value by a radix of at most sixteen, one
// quotient bit per cycle. The quotient is built in place in the dividend
// shift register, so only the remainder path is wide enough to compare.
module rde_divider import rde_pkg::*; #(
  parameter int unsigned VALUE_BITS = rde_pkg::VALUE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rde_div_req_t          req_i,
  input  logic [VALUE_BITS-1:0] dividend_i,
  output rde_div_rsp_t          rsp_o,
  output logic [VALUE_BITS-1:0] quotient_o,
  output logic [DIGIT_W-1:0]    remainder_o
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] quot_q, quot_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [RADIX_W-1:0] trial;
  logic               fits;

  assign trial = {rem_q, quot_q[VALUE_BITS-1]};
  assign fits  = (trial >= req_i.radix);

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quot_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(VALUE_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // The trial stays below twice the radix, so one subtract restores it.
      rem_d  = fits ? DIGIT_W'(trial - req_i.radix) : DIGIT_W'(trial);
      quot_d = {quot_q[VALUE_BITS-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

// File: hdl/radix_digit_emitter_core.sv
// Channel  Dir  Fields                           Transaction
// in_i     in   value[VALUE_BITS-1:0]            valid && ready, one value
// out_o    out  digit[3:0] digit_char[6:0] last  valid && ready, one digit
// apb      in   psel penable pwrite paddr pwdata radix at byte address 0
//
// Each digit comes from the bit-serial divider, and each pop goes through the
// registered stack RAM read. Reset empties the stack pointer and loads radix
// 10; the stack RAM is not cleared. A new value is taken only when the
// previous one has been pushed and popped; a stall on out_o holds the pop
// sequence in place.
module radix_digit_emitter_core import rde_pkg::*; #(
  parameter int unsigned DIGIT_STACK_DEPTH = rde_pkg::DIGIT_STACK_DEPTH,
  parameter int unsigned VALUE_BITS        = rde_pkg::VALUE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rde_in_if.sink             in_i,
  rde_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned AW  = $clog2(DIGIT_STACK_DEPTH);
  localparam int unsigned SPW = $clog2(DIGIT_STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PUSH,
    S_READ,
    S_LOAD
  } state_e;

  state_e state_q, state_d;
  logic [SPW-1:0]     sp_q, sp_d;
  logic [RADIX_W-1:0] radix_q;
  logic               out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0] out_digit_q, out_digit_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;

  rde_div_req_t          div_req;
  rde_div_rsp_t          div_rsp;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_quot;
  logic [DIGIT_W-1:0]    div_rem;

  logic               ram_we;
  logic               ram_re;
  logic [DIGIT_W-1:0] ram_rdata;
  logic [SPW-1:0]     sp_inc;
  logic [SPW-1:0]     sp_dec;
  logic               in_fire;
  logic               out_free;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RADIX)) begin
      radix_q <= pwdata[RADIX_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_RADIX) ? PDATA_W'(radix_q) : '0;
  assign pready = 1'b1;

  assign sp_inc   = sp_q + SPW'(1);
  assign sp_dec   = sp_q - SPW'(1);
  assign in_fire  = in_i.valid && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_digit_d  = out_digit_q;
    out_char_d   = out_char_q;
    out_last_d   = out_last_q;
    div_req.start = 1'b0;
    div_req.radix = eff_radix(radix_q);
    div_dividend = div_quot;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        div_dividend = in_i.value;
        if (in_i.valid) begin
          div_req.start = 1'b1;
          sp_d          = '0;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        ram_we = 1'b1;
        sp_d   = sp_inc;
        // A zero value still pushes its single zero digit before stopping.
        if ((div_quot == '0) || (sp_inc == SPW'(DIGIT_STACK_DEPTH))) begin
          state_d = S_READ;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        sp_d    = sp_dec;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_digit_d = ram_rdata;
          out_char_d  = char_of(ram_rdata);
          out_last_d  = (sp_q == '0);
          state_d     = (sp_q == '0) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_digit_q <= out_digit_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
  end

  rde_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .rsp_o       (div_rsp),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  rde_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (DIGIT_STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (div_rem),
    .re_i    (ram_re),
    .raddr_i (sp_dec[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.digit      = out_digit_q;
  assign out_o.digit_char = out_char_q;
  assign out_o.last_digit = out_last_q;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(DIGIT_STACK_DEPTH))
    else $error("digit stack pointer beyond depth");

  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (sp_q == '0) && !div_rsp.busy)
    else $error("value accepted while the previous one is still in work");

  a_push_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> (RADIX_W'(div_rem) < eff_radix(radix_q)))
    else $error("pushed digit is not below the radix");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_LOAD))
    else $error("digit presented outside the load step");
`endif

endmodule

// File: bench/tb_radix_digit_emitter_core.sv
module tb_radix_digit_emitter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rde_pkg::*;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned END_SETTLE  = 100;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 31;
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [CHAR_W-1:0]  chr;
    logic               last;
  } digit_t;

  typedef struct packed {
    logic [RADIX_W-1:0]    radix;
    logic [VALUE_BITS-1:0] value;
    logic                  typed;
    digit_t                result;
  } directed_row_t;

  // Rows with typed set carry their single expected digit; the rest go through the predictor.
  localparam directed_row_t DIRECTED [23] = '{
    '{5'd10, 31'd0,          1'b1, '{4'd0,  CHAR_W'("0"), 1'b1}},
    '{5'd10, 31'd9,          1'b1, '{4'd9,  CHAR_W'("9"), 1'b1}},
    '{5'd10, 31'd10,         1'b0, '0},
    '{5'd10, 31'd2147483647, 1'b0, '0},
    '{5'd2,  31'd0,          1'b1, '{4'd0,  CHAR_W'("0"), 1'b1}},
    '{5'd2,  31'd1,          1'b1, '{4'd1,  CHAR_W'("1"), 1'b1}},
    '{5'd2,  31'd2147483647, 1'b0, '0},
    '{5'd2,  31'd1073741824, 1'b0, '0},
    '{5'd16, 31'd15,         1'b1, '{4'd15, CHAR_W'("F"), 1'b1}},
    '{5'd16, 31'd10,         1'b1, '{4'd10, CHAR_W'("A"), 1'b1}},
    '{5'd16, 31'd2147483647, 1'b0, '0},
    '{5'd16, 31'h5A5A5A5A,   1'b0, '0},
    '{5'd16, 31'h25A5A5A5,   1'b0, '0},
    '{5'd0,  31'd1,          1'b1, '{4'd1,  CHAR_W'("1"), 1'b1}},
    '{5'd0,  31'd2,          1'b0, '0},
    '{5'd1,  31'd3,          1'b0, '0},
    '{5'd17, 31'd15,         1'b1, '{4'd15, CHAR_W'("F"), 1'b1}},
    '{5'd31, 31'd255,        1'b0, '0},
    '{5'd31, 31'd0,          1'b1, '{4'd0,  CHAR_W'("0"), 1'b1}},
    '{5'd3,  31'd2147483647, 1'b0, '0},
    '{5'd7,  31'd48,         1'b0, '0},
    '{5'd15, 31'd14,         1'b1, '{4'd14, CHAR_W'("E"), 1'b1}},
    '{5'd9,  31'd1000,       1'b0, '0}
  };

  localparam int unsigned TX_IDLE [4]  = '{0, 83, 0, 31};
  localparam int unsigned RX_STALL [4] = '{0, 0, 83, 31};
  localparam logic [RADIX_W-1:0] PHASE_RADIX [7] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd17, 5'd1,
                                                     5'd10};

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  rde_in_if  in_ch ();
  rde_out_if out_ch ();

  radix_digit_emitter_core DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
  digit_t pending_digits [$];
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned mismatches   = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  // Register values outside two to sixteen clamp to the nearest legal base.
  function automatic int unsigned effective_base();
    if (radix_setting < RADIX_MIN) return 32'(RADIX_MIN);
    if (radix_setting > RADIX_MAX) return 32'(RADIX_MAX);
    return 32'(radix_setting);
  endfunction

  function automatic void convert_to_digits(input logic [VALUE_BITS-1:0] v);
    longint unsigned base;
    longint unsigned rest;
    logic [DIGIT_W-1:0] stack [$];
    digit_t d;
    base = 64'(effective_base());
    rest = 64'(v);
    if (rest == 64'd0) stack.push_back(DIGIT_W'(0));
    while (rest != 64'd0 && stack.size() < DIGIT_STACK_DEPTH) begin
      stack.push_back(DIGIT_W'(rest % base));
      rest = rest / base;
    end
    // Remainders come out least significant first, so the stack pops in print order.
    while (stack.size() != 0) begin
      d.digit = stack.pop_back();
      if (d.digit < DIGIT_W'(10)) begin
        d.chr = CHAR_W'("0") + CHAR_W'(d.digit);
      end else begin
        d.chr = CHAR_W'("A") + CHAR_W'(d.digit) - CHAR_W'(10);
      end
      d.last = (stack.size() == 0);
      pending_digits.push_back(d);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    longint unsigned p;
    longint unsigned base;
    int unsigned nb;
    base = 64'(effective_base());
    case ($urandom_range(7))
      0: return VALUE_BITS'($urandom());
      1: begin
        // Powers of the base and one below them sit on a digit count boundary.
        p = 64'd1;
        repeat ($urandom_range(VALUE_BITS)) begin
          if (p * base <= VALUE_MAX) p = p * base;
        end
        return VALUE_BITS'(p - 64'($urandom_range(1)));
      end
      2: return $urandom_range(1) ? VALUE_BITS'(VALUE_MAX) : '0;
      default: begin
        nb = $urandom_range(VALUE_BITS, 1);
        return VALUE_BITS'(64'($urandom()) & ((64'd1 << nb) - 64'd1));
      end
    endcase
  endfunction

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_RADIX, 2'b00});
    pwdata  <= {(PDATA_W - RADIX_W)'($urandom()), r};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    // The register reads back what was written, without the upper bits.
    @(posedge clk);
    if (prdata !== PDATA_W'(r)) begin
      report_mismatch("radix readback", 32'(prdata), 32'(r));
    end
    radix_setting = r;
  endtask

  task automatic send_value(input logic [VALUE_BITS-1:0] v, input logic use_typed,
                            input digit_t typed_result);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (use_typed) begin
      pending_digits.push_back(typed_result);
    end else begin
      convert_to_digits(v);
    end
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_digits();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_digits.size() != 0);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].radix != radix_setting) begin
        drain_digits();
        write_radix(DIRECTED[i].radix);
      end
      send_value(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].result);
    end

    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      drain_digits();
      write_radix((ph < 7) ? PHASE_RADIX[ph] : RADIX_W'($urandom_range(15, 3)));
      tx_idle_pct  = TX_IDLE[ph % 4];
      rx_stall_pct = RX_STALL[ph % 4];
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(24) == 0) begin
          drain_digits();
        end else begin
          idle_gap();
        end
        send_value(pick_value(), 1'b0, '0);
      end
    end

    drain_digits();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    digit_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_digits.size() == 0) begin
          report_mismatch("unexpected digit", 32'(out_ch.digit), 0);
        end else begin
          want = pending_digits.pop_front();
          if (out_ch.digit !== want.digit) begin
            report_mismatch("digit", 32'(out_ch.digit), 32'(want.digit));
          end
          if (out_ch.digit_char !== want.chr) begin
            report_mismatch("digit_char", 32'(out_ch.digit_char), 32'(want.chr));
          end
          if (out_ch.last_digit !== want.last) begin
            report_mismatch("last_digit", 32'(out_ch.last_digit), 32'(want.last));
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
